// File: src/qob_pkg.sv
// Shared constants, types and the sequencer program for the queue offset balancer update.
// No dependencies; imported by the interfaces and by every module of the block.
`default_nettype none

package qob_pkg;

  // Field widths
  localparam int THETA_W = 16;
  localparam int QLEN_W  = 16;
  localparam int DT_W    = 17;
  localparam int OFF_W   = 32;
  localparam int REP_W   = 3;
  localparam int FRAC_W  = 16;

  localparam int DEF_MAX_REPLICAS = 8;

  // dt above 1.0 (Q1.16) is clamped
  localparam logic [DT_W-1:0] DT_ONE = DT_W'(65536);

  // Datapath widths: |error| operand, product, dividend, divisor, offset sum
  localparam int MB_W   = 33;
  localparam int PROD_W = DT_W + MB_W;
  localparam int DVD_W  = PROD_W + 1 - FRAC_W;
  localparam int DVS_W  = 9;
  localparam int SAT_W  = DVD_W + 2;

  // Rounding biases: step one divides by 10*n*2^15 = 5n*2^16 (divider after
  // the 2^16 shift), step two by 100*2^16
  localparam int BIAS1  = 163840;
  localparam int BIAS2  = 3276800;
  localparam int DIV1_K = 5;

  // Step two: 100*2^16 = 25*2^18, so shift by 2^18, then multiply by
  // ceil(2^36/25) and keep the bits above 2^36 (exact for any 32-bit operand)
  localparam int              Y2_SH   = FRAC_W + 2;
  localparam int              Y2_W    = 32;
  localparam int              REC2_SH = 36;
  localparam logic [Y2_W-1:0] REC2_M  = 32'd2748779070;
  localparam int              REC_Q_W = 2 * Y2_W - REC2_SH;

  localparam int PC_W = 4;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_ERR,
    OP_MUL1,
    OP_DIV1,
    OP_OFF1,
    OP_DIFF,
    OP_MUL2,
    OP_DIV2,
    OP_REC,
    OP_EMIT,
    OP_NEXT
  } op_t;

  typedef enum logic [2:0] {
    J_NEVER,
    J_ALWAYS,
    J_LOAD,
    J_DIV_BUSY,
    J_OUT_BUSY,
    J_LAST
  } cond_t;

  typedef struct packed {
    op_t             op;
    cond_t           cond;
    logic [PC_W-1:0] target;
  } ctrl_t;

  typedef struct packed {
    logic             start;
    logic [DVD_W-1:0] dividend;
    logic [DVS_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             busy;
    logic [DVD_W-1:0] quotient;
  } div_rsp_t;

  // Program entry points
  localparam logic [PC_W-1:0] PC_LOAD    = PC_W'(0);
  localparam logic [PC_W-1:0] PC_REPLICA = PC_W'(1);
  localparam logic [PC_W-1:0] PC_WAIT1   = PC_W'(5);
  localparam logic [PC_W-1:0] PC_EMIT    = PC_W'(11);

  // Control store: one word per step; jump to target when the condition holds
  function automatic ctrl_t ucode(input logic [PC_W-1:0] pc);
    ctrl_t w;
    w = '{op: OP_NOP, cond: J_ALWAYS, target: PC_LOAD};
    case (pc)
      4'd0:  w = '{op: OP_NOP,  cond: J_LOAD,     target: PC_LOAD};
      4'd1:  w = '{op: OP_NOP,  cond: J_NEVER,    target: PC_LOAD};
      4'd2:  w = '{op: OP_ERR,  cond: J_NEVER,    target: PC_LOAD};
      4'd3:  w = '{op: OP_MUL1, cond: J_NEVER,    target: PC_LOAD};
      4'd4:  w = '{op: OP_DIV1, cond: J_NEVER,    target: PC_LOAD};
      4'd5:  w = '{op: OP_NOP,  cond: J_DIV_BUSY, target: PC_WAIT1};
      4'd6:  w = '{op: OP_OFF1, cond: J_NEVER,    target: PC_LOAD};
      4'd7:  w = '{op: OP_DIFF, cond: J_NEVER,    target: PC_LOAD};
      4'd8:  w = '{op: OP_MUL2, cond: J_NEVER,    target: PC_LOAD};
      4'd9:  w = '{op: OP_DIV2, cond: J_NEVER,    target: PC_LOAD};
      4'd10: w = '{op: OP_REC,  cond: J_NEVER,    target: PC_LOAD};
      4'd11: w = '{op: OP_EMIT, cond: J_OUT_BUSY, target: PC_EMIT};
      4'd12: w = '{op: OP_NEXT, cond: J_LAST,     target: PC_LOAD};
      4'd13: w = '{op: OP_NOP,  cond: J_ALWAYS,   target: PC_REPLICA};
      default: w = '{op: OP_NOP, cond: J_ALWAYS,  target: PC_LOAD};
    endcase
    return w;
  endfunction

  // Clamp a wide signed sum to the signed 32-bit offset range
  function automatic logic signed [OFF_W-1:0] sat_off(input logic signed [SAT_W-1:0] v);
    logic ovf;
    ovf = (v[SAT_W-1:OFF_W-1] != {(SAT_W-OFF_W+1){1'b0}}) &&
          (v[SAT_W-1:OFF_W-1] != {(SAT_W-OFF_W+1){1'b1}});
    if (!ovf) begin
      return v[OFF_W-1:0];
    end else if (v[SAT_W-1]) begin
      return {1'b1, {(OFF_W-1){1'b0}}};
    end else begin
      return {1'b0, {(OFF_W-1){1'b1}}};
    end
  endfunction

endpackage

`default_nettype wire

// File: src/qob_in_if.sv
// Request channel carrying one replica's theta, queue length, time step and batch mark.
// Depends on qob_pkg for field widths.
`default_nettype none

interface qob_in_if;
  import qob_pkg::*;

  logic                valid;
  logic                ready;
  logic [THETA_W-1:0]  theta;
  logic [QLEN_W-1:0]   queue_length;
  logic [DT_W-1:0]     dt;
  logic                last;

  modport source (output valid, theta, queue_length, dt, last, input ready);
  modport sink   (input valid, theta, queue_length, dt, last, output ready);
endinterface

`default_nettype wire

// File: src/qob_out_if.sv
// Result channel carrying one replica's updated queue offset.
// Depends on qob_pkg for field widths.
`default_nettype none

interface qob_out_if;
  import qob_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [REP_W-1:0]        replica;
  logic signed [OFF_W-1:0] offset;
  logic                    last_out;

  modport source (output valid, replica, offset, last_out, input ready);
  modport sink   (input valid, replica, offset, last_out, output ready);
endinterface

`default_nettype wire

// File: src/qob_div.sv
// Restoring divider, one quotient bit per cycle, used by the first update step.
// Depends on qob_pkg for widths and the request/response structs.
`default_nettype none

module qob_div (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire qob_pkg::div_req_t req,
  output qob_pkg::div_rsp_t      rsp
);
  import qob_pkg::*;

  localparam int CNT_W = $clog2(DVD_W + 1);

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [DVD_W-1:0] dvd;
  logic [DVS_W-1:0] dvs;
  logic [DVS_W-1:0] rem;
  logic [DVS_W:0]   trial;
  logic             qbit;

  // Shift in the next dividend bit and try the subtraction
  assign trial = {rem, dvd[DVD_W-1]};
  assign qbit  = (trial >= {1'b0, dvs});

  // Iteration control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (req.start) begin
      busy <= 1'b1;
      cnt  <= CNT_W'(DVD_W);
    end else if (busy) begin
      cnt <= cnt - CNT_W'(1);
      if (cnt == CNT_W'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  // Partial remainder; quotient bits fill the dividend register from the bottom
  always_ff @(posedge clk) begin
    if (req.start) begin
      dvd <= req.dividend;
      dvs <= req.divisor;
      rem <= '0;
    end else if (busy) begin
      rem <= qbit ? DVS_W'(trial - {1'b0, dvs}) : DVS_W'(trial);
      dvd <= {dvd[DVD_W-2:0], qbit};
    end
  end

  assign rsp.busy     = busy;
  assign rsp.quotient = dvd;

endmodule

`default_nettype wire

// File: src/queue_offset_balancer_update.sv
// Queue offset balancer update: top level with load logic, replica stores,
// microcoded update sequencer and output register. Depends on qob_pkg,
// qob_in_if, qob_out_if and qob_div.
//
//   channel  dir  payload                        handshake
//   item     in   theta, queue_length, dt, last  valid/ready
//   result   out  replica, offset, last_out      valid/ready
//
// Loading accepts one item per cycle; ready is high only while no batch is in update.
// After the closing item each replica is paced mostly by the 35-step divider of
// the first step, which holds the sequencer while it is busy; the second step
// divides by a constant with a reciprocal multiply. Reset (rst, synchronous) clears
// all offsets to zero and empties the batch. A stalled result holds the sequencer
// at the emit step; loading resumes once the last result of the batch is in the
// output register.
`default_nettype none

module queue_offset_balancer_update #(
  parameter int MAX_REPLICAS = qob_pkg::DEF_MAX_REPLICAS
) (
  input wire logic clk,
  input wire logic rst,
  qob_in_if.sink   item,
  qob_out_if.source result
);
  import qob_pkg::*;

  localparam int IDX_W = (MAX_REPLICAS > 1) ? $clog2(MAX_REPLICAS) : 1;
  localparam int CNT_W = $clog2(MAX_REPLICAS + 1);
  localparam int SUM_W = $clog2(MAX_REPLICAS * (2**THETA_W - 1) + 1);
  localparam int DIFF_W = MB_W + 1;

  // Sequencer
  logic [PC_W-1:0] pc;
  logic [PC_W-1:0] pc_next;
  ctrl_t           ctrl;
  logic            take;

  // Batch state
  logic [CNT_W-1:0] count;
  logic [SUM_W-1:0] sum;
  logic [DT_W-1:0]  dt_q;
  logic [IDX_W-1:0] idx;
  logic             idx_last;

  // Stores
  logic [THETA_W-1:0]      theta_mem [MAX_REPLICAS];
  logic [QLEN_W-1:0]       ql_mem    [MAX_REPLICAS];
  logic signed [OFF_W-1:0] off_mem   [MAX_REPLICAS];
  logic [MAX_REPLICAS-1:0] off_vld;
  logic [THETA_W-1:0]      theta_q;
  logic [QLEN_W-1:0]       ql_q;
  logic signed [OFF_W-1:0] off_q;
  logic                    off_vld_q;

  // Datapath
  logic                     accept;
  logic                     store_en;
  logic [IDX_W-1:0]         wr_idx;
  logic [CNT_W+THETA_W-1:0] nt_full;
  logic [SUM_W:0]           err;
  logic [SUM_W:0]           err_mag;
  logic [DIFF_W-1:0]        diff;
  logic [DIFF_W-1:0]        diff_mag;
  logic                     neg;
  logic [MB_W-1:0]          mag_b;
  logic [PROD_W-1:0]        prod;
  logic [PROD_W:0]          bias;
  logic [PROD_W:0]          acc;
  logic [Y2_W-1:0]          y2;
  logic [2*Y2_W-1:0]        rec_prod;
  logic [REC_Q_W-1:0]       q2;
  logic signed [SAT_W-1:0]  q_s;
  logic signed [SAT_W-1:0]  q2_s;
  logic signed [SAT_W-1:0]  off_cur_x;
  logic signed [SAT_W-1:0]  off1_x;
  logic signed [OFF_W-1:0]  off1;
  logic signed [OFF_W-1:0]  off2;
  logic                     out_busy;
  logic                     emit;
  div_req_t                 dreq;
  div_rsp_t                 drsp;

  qob_div u_div (
    .clk (clk),
    .rst (rst),
    .req (dreq),
    .rsp (drsp)
  );

  // Control word and next step
  assign ctrl = ucode(pc);

  always_comb begin
    case (ctrl.cond)
      J_NEVER:    take = 1'b0;
      J_ALWAYS:   take = 1'b1;
      J_LOAD:     take = !(accept && item.last);
      J_DIV_BUSY: take = drsp.busy;
      J_OUT_BUSY: take = out_busy;
      J_LAST:     take = idx_last;
      default:    take = 1'b1;
    endcase
    pc_next = take ? ctrl.target : pc + PC_W'(1);
  end

  // Load side
  assign item.ready = (ctrl.cond == J_LOAD);
  assign accept     = item.valid && item.ready;
  assign store_en   = accept && (count < CNT_W'(MAX_REPLICAS));
  assign wr_idx     = count[IDX_W-1:0];
  assign idx_last   = ((CNT_W'(idx) + CNT_W'(1)) == count);

  // Step one error n*theta - sum, kept exact
  assign nt_full = count * theta_q;
  assign err     = {1'b0, SUM_W'(nt_full)} - {1'b0, sum};
  assign err_mag = err[SUM_W] ? -err : err;

  // Step two difference offset - queue_length*2^16
  assign off1_x   = {{(SAT_W-OFF_W){off1[OFF_W-1]}}, off1};
  assign diff     = DIFF_W'(off1_x) - {1'b0, ql_q, {FRAC_W{1'b0}}};
  assign diff_mag = diff[DIFF_W-1] ? -diff : diff;

  // Rounding bias for the active step; divider request for step one
  always_comb begin
    if (ctrl.op == OP_DIV1) begin
      bias = (PROD_W+1)'(count) * (PROD_W+1)'(BIAS1);
    end else begin
      bias = (PROD_W+1)'(BIAS2);
    end
    acc           = {1'b0, prod} + bias;
    dreq.divisor  = DVS_W'(count) * DVS_W'(DIV1_K);
    dreq.dividend = acc[PROD_W:FRAC_W];
    dreq.start    = (ctrl.op == OP_DIV1);
  end

  // Step two quotient by 25 through the reciprocal
  assign rec_prod = y2 * REC2_M;

  // Signed quotients and the two offset updates
  assign q_s       = neg ? -{2'b00, drsp.quotient} : {2'b00, drsp.quotient};
  assign q2_s      = neg ? -SAT_W'(q2) : SAT_W'(q2);
  assign off_cur_x = off_vld_q ? {{(SAT_W-OFF_W){off_q[OFF_W-1]}}, off_q} : '0;
  assign off2      = sat_off(off1_x - q2_s);

  assign out_busy = result.valid && !result.ready;
  assign emit     = (ctrl.op == OP_EMIT) && !out_busy;

  // Sequencer and batch control
  always_ff @(posedge clk) begin
    if (rst) begin
      pc    <= PC_LOAD;
      count <= '0;
      sum   <= '0;
      dt_q  <= '0;
      idx   <= '0;
    end else begin
      pc <= pc_next;
      if (store_en) begin
        count <= count + CNT_W'(1);
        sum   <= sum + SUM_W'(item.theta);
      end
      if (accept && item.last) begin
        dt_q <= (item.dt > DT_ONE) ? DT_ONE : item.dt;
      end
      if (ctrl.op == OP_NEXT) begin
        if (idx_last) begin
          idx   <= '0;
          count <= '0;
          sum   <= '0;
        end else begin
          idx <= idx + IDX_W'(1);
        end
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    case (ctrl.op)
      OP_ERR: begin
        neg   <= err[SUM_W];
        mag_b <= MB_W'(err_mag[SUM_W-1:0]);
      end
      OP_MUL1, OP_MUL2: begin
        prod <= dt_q * mag_b;
      end
      OP_OFF1: begin
        off1 <= sat_off(off_cur_x + q_s);
      end
      OP_DIFF: begin
        neg   <= diff[DIFF_W-1];
        mag_b <= diff_mag[MB_W-1:0];
      end
      OP_DIV2: begin
        y2 <= acc[Y2_SH+Y2_W-1:Y2_SH];
      end
      OP_REC: begin
        q2 <= rec_prod[2*Y2_W-1:REC2_SH];
      end
      default: begin
      end
    endcase
  end

  // Replica stores: written on load or emit, read at the current replica
  always_ff @(posedge clk) begin
    if (store_en) begin
      theta_mem[wr_idx] <= item.theta;
      ql_mem[wr_idx]    <= item.queue_length;
    end
    if (emit) begin
      off_mem[idx] <= off2;
    end
    theta_q <= theta_mem[idx];
    ql_q    <= ql_mem[idx];
    off_q   <= off_mem[idx];
  end

  // Offsets read as zero until first written
  always_ff @(posedge clk) begin
    if (rst) begin
      off_vld   <= '0;
      off_vld_q <= 1'b0;
    end else begin
      if (emit) begin
        off_vld[idx] <= 1'b1;
      end
      off_vld_q <= off_vld[idx];
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (emit) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      result.replica  <= REP_W'(idx);
      result.offset   <= off2;
      result.last_out <= idx_last;
    end
  end

endmodule

`default_nettype wire
